### rtl/core/lcdmts_pkg.sv
// ----------------------------------------------------------------------------
// lcdmts_pkg
// Types and constants of the lcd mode timing sequencer: mode codes, status
// interrupt sources, register indexes, mode lengths and port widths.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdmts_pkg;

    // port and state widths
    localparam int unsigned CYCLES_W = 8;
    localparam int unsigned LINE_W   = 8;
    localparam int unsigned DOT_W    = 10;
    localparam int unsigned SRC_W    = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    // default frame geometry
    localparam int unsigned DEF_VISIBLE_LINES = 144;
    localparam int unsigned DEF_TOTAL_LINES   = 154;

    // mode lengths in cycles
    localparam logic [DOT_W-1:0] OAM_CYCLES       = DOT_W'(80);
    localparam logic [DOT_W-1:0] TRANSFER_CYCLES  = DOT_W'(172);
    localparam logic [DOT_W-1:0] HBLANK_CYCLES    = DOT_W'(204);
    localparam logic [DOT_W-1:0] LINE_CYCLES      = DOT_W'(80 + 172 + 204);
    localparam logic [DOT_W-1:0] VBLANK_IRQ_DELAY = DOT_W'(24);

    // display mode codes
    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_OAM      = 2'd2,
        MODE_TRANSFER = 2'd3
    } t_mode;

    // status interrupt sources
    typedef enum logic [SRC_W-1:0] {
        SRC_NONE   = 3'd0,
        SRC_HBLANK = 3'd1,
        SRC_VBLANK = 3'd2,
        SRC_OAM    = 3'd3,
        SRC_MATCH  = 3'd4
    } t_stat_src;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DISPLAY_ENABLE  = 2'd0,
        REG_COMPARE_LINE    = 2'd1,
        REG_STAT_IRQ_SOURCE = 2'd2
    } t_cfg_reg;

endpackage : lcdmts_pkg

`default_nettype wire

### rtl/core/lcd_mode_timing_sequencer.sv
// ----------------------------------------------------------------------------
// lcd_mode_timing_sequencer
// Advances the scan timing (oam search, pixel transfer, hblank, vblank) by the
// elapsed cycles of each item and reports mode, line, coincidence and pulses.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+---------------------------
//  input     | in        | i_in_valid / o_in_ready | i_elapsed_cycles
//  result    | out       | o_out_valid/i_out_ready | o_mode .. o_frame_present
//  config    | in        | i_cfg_we (no wait)      | i_cfg_index, i_cfg_data
//
//  one item per clock: the whole step is one add, a few compares and a line
//  increment between the input ports and the result register.
//  the result is registered and appears in the cycle after its item is accepted.
//  the input is taken whenever the result register is empty or being drained,
//  so only a stalled result holds back the input.
//  synchronous active-low reset restores the vblank, line zero state.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_mode_timing_sequencer #(
    parameter int unsigned VISIBLE_LINES = lcdmts_pkg::DEF_VISIBLE_LINES,
    parameter int unsigned TOTAL_LINES   = lcdmts_pkg::DEF_TOTAL_LINES
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,

    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [lcdmts_pkg::CYCLES_W-1:0]    i_elapsed_cycles,

    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [1:0]                              o_mode,
    output logic [lcdmts_pkg::LINE_W-1:0]           o_line,
    output logic                                    o_coincidence,
    output logic                                    o_vblank_irq,
    output logic                                    o_stat_irq,
    output logic                                    o_render_line,
    output logic                                    o_frame_present,

    input  wire logic                               i_cfg_we,
    input  wire logic [lcdmts_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [lcdmts_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import lcdmts_pkg::*;

    localparam logic [LINE_W:0] VISIBLE_END = (LINE_W+1)'(VISIBLE_LINES);
    localparam logic [LINE_W:0] TOTAL_END   = (LINE_W+1)'(TOTAL_LINES);

    // configuration registers
    logic              r_display_enable;
    logic [LINE_W-1:0] r_compare_line;
    logic [SRC_W-1:0]  r_stat_src;

    // timing state
    logic [DOT_W-1:0]  r_dot, n_dot;
    t_mode             r_mode, n_mode;
    logic [LINE_W-1:0] r_line, n_line;
    logic              r_coinc, n_coinc;
    logic              r_vb_pending, n_vb_pending;

    // result register
    logic              r_out_valid;
    t_mode             r_out_mode;
    logic [LINE_W-1:0] r_out_line;
    logic              r_out_coinc;
    logic              r_out_vb;
    logic              r_out_stat;
    logic              r_out_render;

    // step logic
    logic              n_vb;
    logic              n_stat;
    logic              n_render;
    logic [DOT_W-1:0]  dot_sum;
    logic [LINE_W:0]   line_inc;
    logic              accept;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;

    assign dot_sum  = r_dot + DOT_W'(i_elapsed_cycles);
    assign line_inc = {1'b0, r_line} + (LINE_W+1)'(1);

    // one timing step for the presented item
    always_comb begin
        n_dot        = r_dot;
        n_mode       = r_mode;
        n_line       = r_line;
        n_coinc      = r_coinc;
        n_vb_pending = r_vb_pending;
        n_vb         = 1'b0;
        n_stat       = 1'b0;
        n_render     = 1'b0;
        if (r_display_enable) begin
            n_dot = dot_sum;
            case (r_mode)
                MODE_HBLANK: begin
                    if (dot_sum >= HBLANK_CYCLES) begin
                        n_dot   = '0;
                        n_line  = line_inc[LINE_W-1:0];
                        n_coinc = (line_inc[LINE_W-1:0] == r_compare_line);
                        if (n_coinc && r_stat_src == SRC_MATCH) begin
                            n_stat = 1'b1;
                        end
                        if (line_inc == VISIBLE_END) begin
                            n_mode       = MODE_VBLANK;
                            n_vb_pending = 1'b1;
                        end else begin
                            n_mode = MODE_OAM;
                            if (r_stat_src == SRC_OAM) begin
                                n_stat = 1'b1;
                            end
                        end
                    end
                end
                MODE_VBLANK: begin
                    if (r_vb_pending && dot_sum > VBLANK_IRQ_DELAY) begin
                        n_vb         = 1'b1;
                        n_vb_pending = 1'b0;
                        if (r_stat_src == SRC_VBLANK) begin
                            n_stat = 1'b1;
                        end
                    end
                    if (dot_sum >= LINE_CYCLES) begin
                        n_dot  = '0;
                        n_line = line_inc[LINE_W-1:0];
                        if (line_inc >= TOTAL_END) begin
                            n_mode = MODE_OAM;
                            n_line = '0;
                            if (r_stat_src == SRC_OAM) begin
                                n_stat = 1'b1;
                            end
                        end
                        n_coinc = (n_line == r_compare_line);
                        if (n_coinc && r_stat_src == SRC_MATCH) begin
                            n_stat = 1'b1;
                        end
                    end
                end
                MODE_OAM: begin
                    if (dot_sum >= OAM_CYCLES) begin
                        n_dot  = '0;
                        n_mode = MODE_TRANSFER;
                    end
                end
                MODE_TRANSFER: begin
                    if (dot_sum >= TRANSFER_CYCLES) begin
                        n_dot    = '0;
                        n_mode   = MODE_HBLANK;
                        n_render = 1'b1;
                        if (r_stat_src == SRC_HBLANK) begin
                            n_stat = 1'b1;
                        end
                    end
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_enable <= 1'b1;
            r_compare_line   <= '0;
            r_stat_src       <= SRC_NONE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DISPLAY_ENABLE:  r_display_enable <= i_cfg_data[0];
                REG_COMPARE_LINE:    r_compare_line   <= i_cfg_data[LINE_W-1:0];
                REG_STAT_IRQ_SOURCE: r_stat_src       <= i_cfg_data[SRC_W-1:0];
                default: begin
                    r_display_enable <= r_display_enable;
                end
            endcase
        end
    end

    // timing state, advanced once per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot        <= '0;
            r_mode       <= MODE_VBLANK;
            r_line       <= '0;
            r_coinc      <= 1'b1;
            r_vb_pending <= 1'b0;
        end else if (accept) begin
            r_dot        <= n_dot;
            r_mode       <= n_mode;
            r_line       <= n_line;
            r_coinc      <= n_coinc;
            r_vb_pending <= n_vb_pending;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_mode   <= n_mode;
            r_out_line   <= n_line;
            r_out_coinc  <= n_coinc;
            r_out_vb     <= n_vb;
            r_out_stat   <= n_stat;
            r_out_render <= n_render;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_mode          = r_out_mode;
    assign o_line          = r_out_line;
    assign o_coincidence   = r_out_coinc;
    assign o_vblank_irq    = r_out_vb;
    assign o_stat_irq      = r_out_stat;
    assign o_render_line   = r_out_render;
    assign o_frame_present = r_out_vb;

endmodule : lcd_mode_timing_sequencer

`default_nettype wire

### bench/lcd_mode_timing_sequencer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcd_mode_timing_sequencer_tb
// Self-checking bench for the lcd mode timing sequencer. Elapsed-cycle items
// are sent over the input channel, and a scan-timing model in the bench
// predicts mode, line, coincidence and interrupt pulses for each one. Results
// are checked in order. The run covers directed mode edges, frame wrap, vblank
// entry, display freeze, random register settings, idling on both channels
// and a long result stall.
// ----------------------------------------------------------------------------

module lcd_mode_timing_sequencer_tb;

    import lcdmts_pkg::*;

    localparam int unsigned VIS_LINES      = DEF_VISIBLE_LINES;
    localparam int unsigned ALL_LINES      = DEF_TOTAL_LINES;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned WATCHDOG_LIMIT = 3000;

    // one result item of the sequencer
    typedef struct packed {
        t_mode      mode;
        logic [7:0] line;
        logic       coin;
        logic       vblank_irq;
        logic       stat_irq;
        logic       render;
        logic       present;
    } t_scan_status;

    // dut ports
    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  in_valid   = 1'b0;
    logic [CYCLES_W-1:0]   elapsed    = '0;
    logic                  out_ready  = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [1:0]            o_mode;
    logic [LINE_W-1:0]     o_line;
    logic                  o_coincidence;
    logic                  o_vblank_irq;
    logic                  o_stat_irq;
    logic                  o_render_line;
    logic                  o_frame_present;

    // scan timing model state and register copies
    logic [DOT_W-1:0]  dot_cnt   = '0;
    t_mode             cur_mode  = MODE_VBLANK;
    logic [LINE_W-1:0] cur_line  = '0;
    logic              coin_flag = 1'b1;
    logic              vb_pend   = 1'b0;
    logic              disp_en   = 1'b1;
    logic [7:0]        cmp_line  = '0;
    logic [SRC_W-1:0]  irq_src   = '0;

    t_scan_status scan_status_q[$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    logic rx_hold_go  = 1'b0;
    int rx_hold_cnt   = 0;
    int quiet_cycles  = 0;
    int n_errors      = 0;
    int n_items       = 0;
    int n_results     = 0;
    int n_vblank_irq  = 0;
    int n_stat_irq    = 0;
    int n_render      = 0;
    int n_frames      = 0;

    lcd_mode_timing_sequencer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_elapsed_cycles(elapsed),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_mode          (o_mode),
        .o_line          (o_line),
        .o_coincidence   (o_coincidence),
        .o_vblank_irq    (o_vblank_irq),
        .o_stat_irq      (o_stat_irq),
        .o_render_line   (o_render_line),
        .o_frame_present (o_frame_present),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // line compare, returns the status hit for a coincidence source
    function automatic logic update_match();
        coin_flag = (cur_line == cmp_line);
        return coin_flag && (irq_src == SRC_MATCH);
    endfunction

    // advance the scan timing by one item and form its result
    function automatic t_scan_status advance_scan(logic [CYCLES_W-1:0] cyc);
        t_scan_status r;
        logic [8:0]   nxt;
        logic         hit;
        r   = '0;
        hit = 1'b0;
        if (disp_en) begin
            dot_cnt = dot_cnt + DOT_W'(cyc);
            case (cur_mode)
                MODE_HBLANK: begin
                    if (dot_cnt >= HBLANK_CYCLES) begin
                        dot_cnt  = '0;
                        nxt      = {1'b0, cur_line} + 9'd1;
                        cur_line = nxt[7:0];
                        hit      = update_match();
                        if (nxt == VIS_LINES) begin
                            cur_mode = MODE_VBLANK;
                            vb_pend  = 1'b1;
                        end else begin
                            cur_mode = MODE_OAM;
                            if (irq_src == SRC_OAM) hit = 1'b1;
                        end
                    end
                end
                MODE_VBLANK: begin
                    // delayed vblank interrupt, once per frame
                    if (vb_pend && dot_cnt > VBLANK_IRQ_DELAY) begin
                        r.vblank_irq = 1'b1;
                        r.present    = 1'b1;
                        if (irq_src == SRC_VBLANK) hit = 1'b1;
                        vb_pend = 1'b0;
                    end
                    if (dot_cnt >= LINE_CYCLES) begin
                        dot_cnt  = '0;
                        nxt      = {1'b0, cur_line} + 9'd1;
                        cur_line = nxt[7:0];
                        if (nxt >= ALL_LINES) begin
                            cur_mode = MODE_OAM;
                            cur_line = '0;
                            if (irq_src == SRC_OAM) hit = 1'b1;
                        end
                        if (update_match()) hit = 1'b1;
                    end
                end
                MODE_OAM: begin
                    if (dot_cnt >= OAM_CYCLES) begin
                        dot_cnt  = '0;
                        cur_mode = MODE_TRANSFER;
                    end
                end
                default: begin
                    if (dot_cnt >= TRANSFER_CYCLES) begin
                        dot_cnt  = '0;
                        cur_mode = MODE_HBLANK;
                        if (irq_src == SRC_HBLANK) hit = 1'b1;
                        r.render = 1'b1;
                    end
                end
            endcase
        end
        r.mode     = cur_mode;
        r.line     = cur_line;
        r.coin     = coin_flag;
        r.stat_irq = hit;
        return r;
    endfunction

    // elapsed-cycle values: extremes, short instruction-like counts, anything
    function automatic logic [CYCLES_W-1:0] pick_cycles();
        int sel;
        sel = $urandom_range(99);
        if (sel < 5)       return '0;
        else if (sel < 10) return '1;
        else if (sel < 50) return CYCLES_W'($urandom_range(4, 24));
        else               return CYCLES_W'($urandom_range(255));
    endfunction

    // offer one item after a random gap and wait for acceptance
    task automatic send_item(input logic [CYCLES_W-1:0] cyc);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        elapsed  <= cyc;
        do @(posedge i_clk); while (!o_in_ready);
        scan_status_q.push_back(advance_scan(cyc));
        n_items++;
    endtask

    // wait until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        while (scan_status_q.size() != 0) @(posedge i_clk);
    endtask

    // write all registers while idle, plus a write to the unused index
    task automatic set_config(input logic en, input logic [7:0] cmp,
                              input logic [SRC_W-1:0] src);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_DISPLAY_ENABLE;
        cfg_data  <= {7'($urandom), en};
        @(posedge i_clk);
        cfg_index <= REG_COMPARE_LINE;
        cfg_data  <= cmp;
        @(posedge i_clk);
        cfg_index <= REG_STAT_IRQ_SOURCE;
        cfg_data  <= {5'($urandom), src};
        @(posedge i_clk);
        cfg_index <= REG_UNUSED;
        cfg_data  <= 8'($urandom);
        @(posedge i_clk);
        cfg_we  <= 1'b0;
        disp_en = en;
        cmp_line = cmp;
        irq_src = src;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct    <= recv_pct;
    endtask

    // display off: timing frozen, no pulses
    task automatic test_display_freeze();
        set_config(1'b0, 8'd0, SRC_NONE);
        send_item('1);
        send_item('0);
        send_item('1);
        set_config(1'b1, 8'd0, SRC_NONE);
    endtask

    // run out the reset vblank into oam search of line zero
    task automatic test_frame_wrap();
        set_config(1'b1, 8'd0, SRC_OAM);
        set_idling(20, 20);
        while (cur_mode != MODE_OAM) send_item(CYCLES_W'($urandom_range(128, 255)));
    endtask

    // exact and overshooting mode boundaries from oam search at dot zero
    task automatic test_mode_edges();
        set_config(1'b1, 8'd1, SRC_HBLANK);
        send_item(8'd79);
        send_item(8'd1);
        send_item(8'd171);
        send_item(8'd1);
        send_item(8'd203);
        send_item(8'd1);
        set_config(1'b1, 8'd2, SRC_MATCH);
        send_item('1);
        send_item('1);
        send_item('1);
        set_config(1'b1, 8'd255, SRC_OAM);
        send_item(8'd80);
        send_item(8'd172);
        send_item(8'd204);
        send_item('0);
    endtask

    // last visible hblank into vblank, irq just past the delay
    task automatic test_vblank_entry();
        set_config(1'b1, 8'(VIS_LINES), SRC_NONE);
        set_idling(10, 10);
        while (!(cur_mode == MODE_HBLANK && cur_line == VIS_LINES - 1))
            send_item(CYCLES_W'($urandom_range(128, 255)));
        set_config(1'b1, 8'(VIS_LINES), SRC_VBLANK);
        send_item(CYCLES_W'(HBLANK_CYCLES - dot_cnt));
        send_item(8'd24);
        send_item(8'd1);
    endtask

    // random settings under each idling pattern
    task automatic test_random_phases();
        int recv_pcts[4];
        int send_pcts[4];
        logic [7:0] cmp;
        send_pcts = '{0, 63, 0, 31};
        recv_pcts = '{0, 0, 63, 31};
        for (int ph = 0; ph < 4; ph++) begin
            for (int seg = 0; seg < 3; seg++) begin
                if (ph == 0 && seg == 0) begin
                    set_config(1'b1, 8'd0, SRC_NONE);
                end else if (ph == 3 && seg == 2) begin
                    set_config(1'b1, 8'd255, SRC_W'(7));
                end else begin
                    cmp = ($urandom_range(3) == 0) ? 8'($urandom)
                                                   : 8'($urandom_range(ALL_LINES - 1));
                    set_config($urandom_range(9) != 0, cmp,
                               SRC_W'($urandom_range(7)));
                end
                set_idling(send_pcts[ph], recv_pcts[ph]);
                for (int k = 0; k < 50; k++) send_item(pick_cycles());
            end
        end
    endtask

    // long result stall while items keep coming
    task automatic test_result_stall();
        set_config(1'b1, 8'($urandom_range(ALL_LINES - 1)), SRC_MATCH);
        set_idling(0, 0);
        rx_hold_go <= 1'b1;
        for (int k = 0; k < 40; k++) send_item(pick_cycles());
        while (rx_hold_cnt < RX_HOLD_CYCLES) @(posedge i_clk);
        rx_hold_go <= 1'b0;
    endtask

    // result receiver with random stalls and an optional long hold
    always @(posedge i_clk) begin
        if (rx_hold_go && rx_hold_cnt < RX_HOLD_CYCLES) begin
            rx_hold_cnt <= rx_hold_cnt + 1;
            out_ready   <= 1'b0;
        end else begin
            if (!rx_hold_go) rx_hold_cnt <= 0;
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic report_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
        n_errors++;
    endtask

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_scan_status want;
        t_scan_status got;
        if (i_rst_n) begin
            if (o_out_valid && out_ready) begin
                got = {t_mode'(o_mode), o_line, o_coincidence, o_vblank_irq, o_stat_irq,
                       o_render_line, o_frame_present};
                if (scan_status_q.size() == 0) begin
                    $display("%0t: result with nothing expected, actual mode %0d line %0d",
                             $realtime, o_mode, o_line);
                    n_errors++;
                end else begin
                    want = scan_status_q.pop_front();
                    n_results++;
                    if (want.vblank_irq) n_vblank_irq++;
                    if (want.stat_irq)   n_stat_irq++;
                    if (want.render)     n_render++;
                    if (want.present)    n_frames++;
                    if (got.mode !== want.mode)
                        report_field("mode", 8'(want.mode), 8'(got.mode));
                    if (got.line !== want.line)
                        report_field("line", want.line, got.line);
                    if (got.coin !== want.coin)
                        report_field("coincidence", 8'(want.coin), 8'(got.coin));
                    if (got.vblank_irq !== want.vblank_irq)
                        report_field("vblank_irq", 8'(want.vblank_irq), 8'(got.vblank_irq));
                    if (got.stat_irq !== want.stat_irq)
                        report_field("stat_irq", 8'(want.stat_irq), 8'(got.stat_irq));
                    if (got.render !== want.render)
                        report_field("render_line", 8'(want.render), 8'(got.render));
                    if (got.present !== want.present)
                        report_field("frame_present", 8'(want.present), 8'(got.present));
                end
            end
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready) || cfg_we) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles, %0d results outstanding",
                         $realtime, quiet_cycles, scan_status_q.size());
                $display("TB_ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // test sequence
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_display_freeze();
        test_frame_wrap();
        test_mode_edges();
        test_vblank_entry();
        test_random_phases();
        test_result_stall();
        drain();
        repeat (8) @(posedge i_clk);
        $display("covered %0d items and %0d results: %0d vblank irqs, %0d status irqs,",
                 n_items, n_results, n_vblank_irq, n_stat_irq);
        $display("%0d rendered lines, %0d frames, all sources, display off and a long stall",
                 n_render, n_frames);
        if (n_errors == 0 && scan_status_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
